[rtl/core/tkm_pkg.sv]
// Shared types and constants of the timestamp k-mutex node.
// No dependencies; imported by every module of the block but tkm_ram.
`timescale 1ns / 1ps
package tkm_pkg;

  localparam int MAX_NODES  = 16;
  localparam int NODE_AW    = $clog2(MAX_NODES);
  localparam int NID_W      = 5;
  localparam int RES_TYPES  = 3;
  localparam int RES_DEPTH  = RES_TYPES * MAX_NODES;
  localparam int RES_AW     = $clog2(RES_DEPTH);
  localparam int TASK_DEPTH = 256;
  localparam int TASK_AW    = $clog2(TASK_DEPTH);
  localparam int STAMP_W    = 32;
  localparam int CNT_W      = 16;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 5;

  // message type codes
  localparam logic [3:0] MT_REQ_ENTRY = 4'd0;
  localparam logic [3:0] MT_ACK       = 4'd1;
  localparam logic [3:0] MT_REL_ENTRY = 4'd2;
  localparam logic [3:0] MT_REQ_RES0  = 4'd3;
  localparam logic [3:0] MT_REQ_RES1  = 4'd4;
  localparam logic [3:0] MT_REQ_RES2  = 4'd5;
  localparam logic [3:0] MT_REL_RES0  = 4'd6;
  localparam logic [3:0] MT_REL_RES1  = 4'd7;
  localparam logic [3:0] MT_REL_RES2  = 4'd8;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_REQ_ENTRY,
    OP_REL_ENTRY,
    OP_REQ_RES,
    OP_REL_RES
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_REQ     = 2'd1,
    ST_STARTED = 2'd2
  } status_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_NODE_ID    = 3'd0,
    CFG_NODE_COUNT = 3'd1,
    CFG_CAP0       = 3'd2,
    CFG_CAP1       = 3'd3,
    CFG_CAP2       = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [NID_W-1:0] node_id;
    logic [NID_W-1:0] node_count;
    logic [NID_W-1:0] cap0;
    logic [NID_W-1:0] cap1;
    logic [NID_W-1:0] cap2;
  } cfg_t;

  // classified message handed from front to back
  typedef struct packed {
    logic [NID_W-1:0]   src;
    logic               is_coord;
    logic               is_peer;
    logic [NODE_AW-1:0] peer;
    op_e                op;
    logic [1:0]         rtype;
    logic [STAMP_W-1:0] stamp;
    logic [1:0]         equip;
  } msg_t;

  typedef struct packed {
    logic               ack_valid;
    logic [NID_W-1:0]   ack_dest;
    logic [STAMP_W-1:0] clock_now;
    logic [NID_W-1:0]   entry_rank;
    logic               entry_grant;
    logic [CNT_W-1:0]   task_slot;
    logic [1:0]         task_kind;
    logic [NID_W-1:0]   res_rank;
    logic               res_grant;
    logic               own_idle;
  } result_t;

endpackage

[rtl/core/timestamp_k_mutex_node.sv]
// Top level of the timestamp k-mutex node: configuration registers,
// front queue and back end. Depends on tkm_pkg, tkm_front, tkm_back.
//
// Usage:
//   Requests enter through a queue interface: present source_i, msg_type_i,
//   stamp_i and equipment_i with push high; the request is taken when full
//   is low. Results leave through a queue interface: while empty is low the
//   oldest result is on the result ports, and pop takes it.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 node_id, 1 node_count, 2..4 capacity of resource types 0..2);
//   write only while the block is idle.
// Request flow:
//   each request passes from acceptance to result through a hand-over
//   from the input queue, a table update, an own-entry read, the rank
//   walk over the sixteen peer slots (one table read per cycle through the
//   table RAMs), a task-store read and the result write. Requests are
//   handled one at a time; a two-entry input queue takes more while one
//   is at work.
// Reset: clock, counters, status and valid bits clear; registers take
//   their defaults. Stamp tables and the task store are not cleared.
// Stall: with a result waiting and pop low, the back end finishes the next
//   request and holds it; the input queue fills and full rises.
`timescale 1ns / 1ps
module timestamp_k_mutex_node (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tkm_pkg::CFG_AW-1:0]  cfg_idx_i,
  input  logic [tkm_pkg::CFG_DW-1:0]  cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic [4:0]                  source_i,
  input  logic [3:0]                  msg_type_i,
  input  logic [31:0]                 stamp_i,
  input  logic [1:0]                  equipment_i,
  output logic                        empty,
  input  logic                        pop,
  output logic                        ack_valid_o,
  output logic [4:0]                  ack_dest_o,
  output logic [31:0]                 clock_now_o,
  output logic [4:0]                  entry_rank_o,
  output logic                        entry_grant_o,
  output logic [15:0]                 task_slot_o,
  output logic [1:0]                  task_kind_o,
  output logic [4:0]                  res_rank_o,
  output logic                        res_grant_o,
  output logic                        own_idle_o
);
  import tkm_pkg::*;

  cfg_t    cfg_q;
  msg_t    msg;
  logic    msg_valid, msg_ready, res_valid;
  result_t res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_id    <= NID_W'(1);
      cfg_q.node_count <= NID_W'(4);
      cfg_q.cap0       <= NID_W'(4);
      cfg_q.cap1       <= NID_W'(2);
      cfg_q.cap2       <= NID_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_NODE_ID:    cfg_q.node_id    <= cfg_data_i;
        CFG_NODE_COUNT: cfg_q.node_count <= cfg_data_i;
        CFG_CAP0:       cfg_q.cap0       <= cfg_data_i;
        CFG_CAP1:       cfg_q.cap1       <= cfg_data_i;
        CFG_CAP2:       cfg_q.cap2       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // request queue and decode
  tkm_front u_front (
    .clk_i, .rst_ni, .push, .full,
    .source_i, .msg_type_i, .stamp_i, .equipment_i,
    .msg_valid_o(msg_valid), .msg_o(msg), .msg_ready_i(msg_ready)
  );

  // table update, ranking and result register
  tkm_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .msg_valid_i(msg_valid), .msg_i(msg), .msg_ready_o(msg_ready),
    .res_valid_o(res_valid), .res_o(res), .res_pop_i(pop)
  );

  assign empty         = !res_valid;
  assign ack_valid_o   = res.ack_valid;
  assign ack_dest_o    = res.ack_dest;
  assign clock_now_o   = res.clock_now;
  assign entry_rank_o  = res.entry_rank;
  assign entry_grant_o = res.entry_grant;
  assign task_slot_o   = res.task_slot;
  assign task_kind_o   = res.task_kind;
  assign res_rank_o    = res.res_rank;
  assign res_grant_o   = res.res_grant;
  assign own_idle_o    = res.own_idle;

endmodule

[rtl/core/tkm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tkm_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/tkm_front.sv]
// Front end: two-entry input queue that decodes each incoming request.
// Depends on tkm_pkg.
`timescale 1ns / 1ps
module tkm_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [tkm_pkg::NID_W-1:0]     source_i,
  input  logic [3:0]                    msg_type_i,
  input  logic [tkm_pkg::STAMP_W-1:0]   stamp_i,
  input  logic [1:0]                    equipment_i,
  output logic                          msg_valid_o,
  output tkm_pkg::msg_t                 msg_o,
  input  logic                          msg_ready_i
);
  import tkm_pkg::*;

  msg_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  msg_t       dec;
  logic       do_push, do_pop;

  // classify the request
  always_comb begin
    dec          = '0;
    dec.src      = source_i;
    dec.stamp    = stamp_i;
    dec.equip    = equipment_i;
    dec.is_coord = (source_i == '0);
    dec.is_peer  = (source_i != '0) && (source_i <= NID_W'(MAX_NODES));
    dec.peer     = NODE_AW'(source_i - NID_W'(1));
    dec.op       = OP_NONE;
    dec.rtype    = '0;
    case (msg_type_i) inside
      MT_REQ_ENTRY: dec.op = OP_REQ_ENTRY;
      MT_REL_ENTRY: dec.op = OP_REL_ENTRY;
      [MT_REQ_RES0:MT_REQ_RES2]: begin
        dec.op    = OP_REQ_RES;
        dec.rtype = 2'(msg_type_i - MT_REQ_RES0);
      end
      [MT_REL_RES0:MT_REL_RES2]: begin
        dec.op    = OP_REL_RES;
        dec.rtype = 2'(msg_type_i - MT_REL_RES0);
      end
      default: dec.op = OP_NONE;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign do_push     = push && !full;
  assign msg_valid_o = (cnt_q != 2'd0);
  assign do_pop      = msg_valid_o && msg_ready_i;
  assign msg_o       = slot_q[rd_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= dec;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

[rtl/core/tkm_back.sv]
// Back end: table update, rank walk over all peers and result register.
// Depends on tkm_pkg and tkm_ram.
`timescale 1ns / 1ps
module tkm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tkm_pkg::cfg_t        cfg_i,
  input  logic                 msg_valid_i,
  input  tkm_pkg::msg_t        msg_i,
  output logic                 msg_ready_o,
  output logic                 res_valid_o,
  output tkm_pkg::result_t     res_o,
  input  logic                 res_pop_i
);
  import tkm_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_UPD, S_OWN, S_WALK, S_SLOT, S_FIN} state_e;

  state_e             state_q;
  msg_t               m_q;
  logic [STAMP_W-1:0] clk_q;
  logic [1:0]         status_q [MAX_NODES];
  logic [RES_DEPTH-1:0] rvld_q;
  logic [MAX_NODES-1:0] hvld_q;
  logic [CNT_W-1:0]   total_q, started_q;
  logic [NID_W-1:0]   cnt_q;
  logic [NODE_AW-1:0] rdi_q;
  logic [1:0]         st_rd_q;
  logic               rv_rd_q, hv_rd_q;
  logic [1:0]         rt_q;
  logic               has_t_q, own_req_q, own_idle_q, heard_all_q;
  logic [STAMP_W-1:0] own_h_q, own_e_q, own_r_q;
  logic [NID_W-1:0]   erank_q, rrank_q;
  logic               egrant_q;
  logic [CNT_W-1:0]   slot_q;
  logic               out_vld_q;
  result_t            out_q;

  logic [STAMP_W-1:0] mx, nclk;
  logic               own_ok;
  logic [NODE_AW-1:0] own_idx, rd_idx;
  logic [NID_W-1:0]   lim, node;
  logic               peer_ok;
  logic [STAMP_W-1:0] h_rd_raw;
  logic [STAMP_W-1:0] h_rd, e_rd, r_rd;
  logic [1:0]         k_rd;
  logic [1:0]         t_sel;
  logic               t_any;
  logic [CNT_W-1:0]   pending, slot_nx;
  logic               upd, store_we;
  logic [NID_W-1:0]   cap_sel;
  logic               fin_go;

  // clock update and own slot
  assign mx      = (m_q.stamp > clk_q) ? m_q.stamp : clk_q;
  assign nclk    = (&mx) ? mx : mx + STAMP_W'(1);
  assign own_ok  = (cfg_i.node_id != '0) && (cfg_i.node_id <= NID_W'(MAX_NODES));
  assign own_idx = NODE_AW'(cfg_i.node_id - NID_W'(1));
  assign lim     = (cfg_i.node_count > NID_W'(MAX_NODES)) ? NID_W'(MAX_NODES)
                                                          : cfg_i.node_count;
  assign rd_idx  = (state_q == S_OWN) ? own_idx : cnt_q[NODE_AW-1:0];
  assign upd     = (state_q == S_UPD);
  assign store_we = upd && m_q.is_coord && (total_q != '1);
  assign fin_go  = (state_q == S_FIN) && (!out_vld_q || res_pop_i);

  // node under comparison in the walk
  assign node    = NID_W'(rdi_q) + NID_W'(1);
  assign peer_ok = (node <= lim) && (node != cfg_i.node_id);
  assign h_rd    = hv_rd_q ? h_rd_raw : '0;

  // lowest resource type with an own request
  always_comb begin
    t_sel = 2'd0;
    t_any = 1'b0;
    for (int t = RES_TYPES - 1; t >= 0; t--) begin
      if (rvld_q[RES_AW'(t * MAX_NODES) + RES_AW'(own_idx)]) begin
        t_sel = 2'(t);
        t_any = 1'b1;
      end
    end
  end

  assign pending = (total_q > started_q) ? total_q - started_q : '0;
  assign slot_nx = started_q + CNT_W'(erank_q) - CNT_W'(1);

  always_comb begin
    case (rt_q)
      2'd0:    cap_sel = cfg_i.cap0;
      2'd1:    cap_sel = cfg_i.cap1;
      default: cap_sel = cfg_i.cap2;
    endcase
  end

  // table memories
  tkm_ram #(.Width(STAMP_W), .Depth(MAX_NODES)) u_heard (
    .clk_i, .we_i(upd && m_q.is_peer), .waddr_i(m_q.peer), .wdata_i(nclk),
    .raddr_i(rd_idx), .rdata_o(h_rd_raw)
  );

  tkm_ram #(.Width(STAMP_W), .Depth(MAX_NODES)) u_entry (
    .clk_i, .we_i(upd && m_q.is_peer && (m_q.op == OP_REQ_ENTRY)),
    .waddr_i(m_q.peer), .wdata_i(m_q.stamp), .raddr_i(rd_idx), .rdata_o(e_rd)
  );

  tkm_ram #(.Width(STAMP_W), .Depth(RES_DEPTH)) u_res (
    .clk_i, .we_i(upd && m_q.is_peer && (m_q.op == OP_REQ_RES)),
    .waddr_i(RES_AW'(m_q.rtype * MAX_NODES) + RES_AW'(m_q.peer)),
    .wdata_i(m_q.stamp),
    .raddr_i(RES_AW'(((state_q == S_OWN) ? t_sel : rt_q) * MAX_NODES) + RES_AW'(rd_idx)),
    .rdata_o(r_rd)
  );

  tkm_ram #(.Width(2), .Depth(TASK_DEPTH)) u_store (
    .clk_i, .we_i(store_we), .waddr_i(total_q[TASK_AW-1:0]), .wdata_i(m_q.equip),
    .raddr_i(slot_nx[TASK_AW-1:0]), .rdata_o(k_rd)
  );

  assign msg_ready_o = (state_q == S_IDLE);
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  // sequencer, tables and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      clk_q     <= '0;
      for (int i = 0; i < MAX_NODES; i++) status_q[i] <= ST_IDLE;
      rvld_q    <= '0;
      hvld_q    <= '0;
      total_q   <= '0;
      started_q <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      // result register hand-off
      if (fin_go) begin
        out_vld_q <= 1'b1;
      end else if (res_pop_i) begin
        out_vld_q <= 1'b0;
      end
      // registered table reads at the shared index
      rdi_q   <= rd_idx;
      st_rd_q <= status_q[rd_idx];
      hv_rd_q <= hvld_q[rd_idx];
      rv_rd_q <= rvld_q[RES_AW'(((state_q == S_OWN) ? t_sel : rt_q) * MAX_NODES)
                        + RES_AW'(rd_idx)];
      case (state_q)
        S_IDLE: begin
          if (msg_valid_i) begin
            m_q     <= msg_i;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          clk_q <= nclk;
          if (store_we) total_q <= total_q + CNT_W'(1);
          if (m_q.is_peer) begin
            hvld_q[m_q.peer] <= 1'b1;
            case (m_q.op)
              OP_REQ_ENTRY: status_q[m_q.peer] <= ST_REQ;
              OP_REL_ENTRY: begin
                status_q[m_q.peer] <= ST_STARTED;
                if (started_q != '1) started_q <= started_q + CNT_W'(1);
              end
              OP_REQ_RES:
                rvld_q[RES_AW'(m_q.rtype * MAX_NODES) + RES_AW'(m_q.peer)] <= 1'b1;
              OP_REL_RES: begin
                rvld_q[RES_AW'(m_q.rtype * MAX_NODES) + RES_AW'(m_q.peer)] <= 1'b0;
                status_q[m_q.peer] <= ST_IDLE;
              end
              default: ;
            endcase
          end
          state_q <= S_OWN;
        end
        S_OWN: begin
          rt_q        <= t_sel;
          has_t_q     <= t_any;
          heard_all_q <= 1'b1;
          erank_q     <= NID_W'(1);
          rrank_q     <= NID_W'(1);
          cnt_q       <= '0;
          state_q     <= S_WALK;
        end
        S_WALK: begin
          if (cnt_q == '0) begin
            // own entries arrive first
            own_h_q    <= h_rd;
            own_e_q    <= e_rd;
            own_r_q    <= r_rd;
            own_req_q  <= (st_rd_q == ST_REQ);
            own_idle_q <= (st_rd_q == ST_IDLE);
          end else if (peer_ok) begin
            if (h_rd <= own_h_q) heard_all_q <= 1'b0;
            if ((st_rd_q == ST_REQ) &&
                ((e_rd < own_e_q) || ((e_rd == own_e_q) && (node < cfg_i.node_id))))
              erank_q <= erank_q + NID_W'(1);
            if (rv_rd_q &&
                ((r_rd < own_r_q) || ((r_rd == own_r_q) && (node < cfg_i.node_id))))
              rrank_q <= rrank_q + NID_W'(1);
          end
          cnt_q <= cnt_q + NID_W'(1);
          if (cnt_q == NID_W'(MAX_NODES)) state_q <= S_SLOT;
        end
        S_SLOT: begin
          egrant_q <= own_ok && own_req_q && heard_all_q && (pending != '0) &&
                      (CNT_W'(erank_q) <= pending);
          slot_q   <= slot_nx;
          state_q  <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_q.ack_valid       <= m_q.is_peer && (m_q.op != OP_NONE);
            out_q.ack_dest        <= (m_q.is_peer && (m_q.op != OP_NONE)) ? m_q.src : '0;
            out_q.clock_now       <= clk_q;
            out_q.entry_rank      <= (own_ok && own_req_q) ? erank_q : NID_W'(1);
            out_q.entry_grant     <= egrant_q;
            out_q.task_slot       <= egrant_q ? slot_q : '0;
            out_q.task_kind       <= egrant_q ? k_rd : '0;
            out_q.res_rank        <= (own_ok && has_t_q) ? rrank_q : NID_W'(1);
            out_q.res_grant       <= own_ok && has_t_q && heard_all_q &&
                                     (rrank_q <= cap_sel);
            out_q.own_idle        <= own_ok && own_idle_q;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
